// ===== rtl/core/rv64_integer_execute_assert.svh =====
// Assertion macros for the integer execute block.
`ifndef RV64_INTEGER_EXECUTE_ASSERT_SVH
`define RV64_INTEGER_EXECUTE_ASSERT_SVH
`ifndef SYNTH
`define RVX_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rvx assertion failed");
`define RVX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rvx assertion failed");
`else
`define RVX_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RVX_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/rvx_pkg.sv =====
// Shared types, codes and helpers of the integer execute block.
package rvx_pkg;

    localparam int DIV_STEPS = 64;
    localparam int DIV_FIRST = 4;
    localparam int STAGES    = DIV_FIRST + DIV_STEPS;

    localparam logic [1:0] OUT_EXEC = 2'd0;
    localparam logic [1:0] OUT_TRAP = 2'd1;
    localparam logic [1:0] OUT_FPU  = 2'd2;

    localparam logic [3:0] CAUSE_ILLEGAL    = 4'd2;
    localparam logic [3:0] CAUSE_BREAKPOINT = 4'd3;
    localparam logic [3:0] CAUSE_ECALL_BASE = 4'd8;

    localparam logic [1:0] PRIV_M = 2'd3;

    localparam logic [6:0] OP_LUI      = 7'h37;
    localparam logic [6:0] OP_AUIPC    = 7'h17;
    localparam logic [6:0] OP_JAL      = 7'h6f;
    localparam logic [6:0] OP_JALR     = 7'h67;
    localparam logic [6:0] OP_BRANCH   = 7'h63;
    localparam logic [6:0] OP_LOAD     = 7'h03;
    localparam logic [6:0] OP_LOAD_FP  = 7'h07;
    localparam logic [6:0] OP_STORE    = 7'h23;
    localparam logic [6:0] OP_STORE_FP = 7'h27;
    localparam logic [6:0] OP_AMO      = 7'h2f;
    localparam logic [6:0] OP_IMM      = 7'h13;
    localparam logic [6:0] OP_IMM_32   = 7'h1b;
    localparam logic [6:0] OP_REG      = 7'h33;
    localparam logic [6:0] OP_REG_32   = 7'h3b;
    localparam logic [6:0] OP_MISC_MEM = 7'h0f;
    localparam logic [6:0] OP_SYSTEM   = 7'h73;
    localparam logic [6:0] OP_MADD     = 7'h43;
    localparam logic [6:0] OP_MSUB     = 7'h47;
    localparam logic [6:0] OP_NMSUB    = 7'h4b;
    localparam logic [6:0] OP_NMADD    = 7'h4f;
    localparam logic [6:0] OP_FP       = 7'h53;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_DIV    = 3'd4;

    localparam logic [2:0] F3_LD     = 3'd3;
    localparam logic [2:0] F3_LDU_MAX = 3'd6;
    localparam logic [2:0] F3_SD     = 3'd3;
    localparam logic [2:0] F3_FLW    = 3'd2;
    localparam logic [2:0] F3_FLD    = 3'd3;
    localparam logic [2:0] F3_AMO_W  = 3'd2;
    localparam logic [2:0] F3_AMO_D  = 3'd3;
    localparam logic [2:0] F3_FENCE  = 3'd0;
    localparam logic [2:0] F3_FENCEI = 3'd1;
    localparam logic [2:0] F3_PRIV   = 3'd0;
    localparam logic [2:0] F3_CSR_RSV = 3'd4;
    localparam logic [2:0] F3_CSRRWI = 3'd5;

    localparam logic [1:0] CSR_OP_WRITE = 2'd1;
    localparam logic [1:0] CSR_OP_SET   = 2'd2;

    localparam logic [6:0] F7_BASE   = 7'd0;
    localparam logic [6:0] F7_ALT    = 7'd32;
    localparam logic [6:0] F7_MULDIV = 7'd1;
    localparam logic [5:0] F6_BASE   = 6'd0;
    localparam logic [5:0] F6_ALT    = 6'd16;
    localparam logic [4:0] AMO_LR    = 5'd2;

    localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INSN_MRET   = 32'h3020_0073;
    localparam logic [31:0] INSN_WFI    = 32'h1050_0073;
    localparam logic [31:0] UIMM_MASK   = 32'hffff_f000;

    localparam logic [11:0] CSR_FFLAGS     = 12'h001;
    localparam logic [11:0] CSR_FRM        = 12'h002;
    localparam logic [11:0] CSR_FCSR       = 12'h003;
    localparam logic [11:0] CSR_CYCLE      = 12'hc00;
    localparam logic [11:0] CSR_TIME       = 12'hc01;
    localparam logic [11:0] CSR_INSTRET    = 12'hc02;
    localparam logic [11:0] CSR_MCYCLE     = 12'hb00;
    localparam logic [11:0] CSR_MINSTRET   = 12'hb02;
    localparam logic [11:0] CSR_MVENDORID  = 12'hf11;
    localparam logic [11:0] CSR_MARCHID    = 12'hf12;
    localparam logic [11:0] CSR_MIMPID     = 12'hf13;
    localparam logic [11:0] CSR_MHARTID    = 12'hf14;
    localparam logic [11:0] CSR_MCONFIGPTR = 12'hf15;
    localparam logic [11:0] CSR_MSTATUS    = 12'h300;
    localparam logic [11:0] CSR_MISA       = 12'h301;
    localparam logic [11:0] CSR_MIE        = 12'h304;
    localparam logic [11:0] CSR_MTVEC      = 12'h305;
    localparam logic [11:0] CSR_MCOUNTEREN = 12'h306;
    localparam logic [11:0] CSR_MSCRATCH   = 12'h340;
    localparam logic [11:0] CSR_MEPC       = 12'h341;
    localparam logic [11:0] CSR_MCAUSE     = 12'h342;
    localparam logic [11:0] CSR_MTVAL      = 12'h343;
    localparam logic [11:0] CSR_MIP        = 12'h344;
    localparam logic [1:0]  CSR_RO_TOP     = 2'd3;

    typedef enum logic [1:0] {
        U_ALU,
        U_MUL,
        U_DIV
    } t_unit;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [3:0]  trap_cause;
        logic [63:0] trap_value;
        logic [63:0] result_value;
        logic        redirect;
        logic [63:0] target;
        logic [63:0] mem_addr;
        logic [63:0] mem_data;
        logic        csr_write;
        logic [11:0] csr_number;
        logic [63:0] csr_new_value;
    } t_res;

    typedef struct packed {
        t_unit      unit;
        logic       word;
        logic [1:0] mulf;
    } t_ctl;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dvs;
        logic        neg_q;
        logic        neg_r;
        logic        is_rem;
        logic        zero;
    } t_div;

    function automatic logic [63:0] sx32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

endpackage

// ===== rtl/core/rvx_chan_if.sv =====
// Valid/ready channel interfaces for the execute block input and result.
interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] insn;
    logic [63:0] pc;
    logic [2:0]  insn_len;
    logic [63:0] rs1_value;
    logic [63:0] rs2_value;
    logic [63:0] rs2_fp_value;
    logic [1:0]  privilege;
    logic        fp_enabled;
    logic [2:0]  counter_enable;
    logic [63:0] csr_data;
    logic [63:0] cycle_count;
    logic [63:0] retired_count;

    modport source (
        output valid, insn, pc, insn_len, rs1_value, rs2_value, rs2_fp_value,
               privilege, fp_enabled, counter_enable, csr_data, cycle_count,
               retired_count,
        input  ready
    );
    modport sink (
        input  valid, insn, pc, insn_len, rs1_value, rs2_value, rs2_fp_value,
               privilege, fp_enabled, counter_enable, csr_data, cycle_count,
               retired_count,
        output ready
    );
endinterface

interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [3:0]  trap_cause;
    logic [63:0] trap_value;
    logic [63:0] result_value;
    logic        redirect;
    logic [63:0] target;
    logic [63:0] mem_addr;
    logic [63:0] mem_data;
    logic        csr_write;
    logic [11:0] csr_number;
    logic [63:0] csr_new_value;

    modport source (
        output valid, outcome, trap_cause, trap_value, result_value, redirect,
               target, mem_addr, mem_data, csr_write, csr_number, csr_new_value,
        input  ready
    );
    modport sink (
        input  valid, outcome, trap_cause, trap_value, result_value, redirect,
               target, mem_addr, mem_data, csr_write, csr_number, csr_new_value,
        output ready
    );
endinterface

// ===== rtl/core/rv64_integer_execute.sv =====
// Top level of the pipelined RV64IM integer execute block.
//
// Input channel i_in carries one decoded instruction with its operands, pc,
// length, privilege and CSR view; it is accepted when valid and ready are
// both high. Result channel o_out carries one result item per accepted
// item, in order: executed outcome, trap or floating-point hand-off.
// From acceptance to o_out.valid an item passes one decode/ALU stage,
// three multiplier stages (32x32 partial products, cross sum, final sum),
// 64 one-bit divider stages, then the output register. All instructions
// take the same path so order is kept. Throughput is one item per cycle
// while the skid entry is empty. An output register plus a one-entry skid
// register sit at the end: when the receiver stalls the skid takes one more
// result, then every stage holds in place (ready drops) until the skid drains.
// Reset clears all valid bits; nothing else is held between items.
`include "rv64_integer_execute_assert.svh"
module rv64_integer_execute
    import rvx_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rvx_in_if.sink        i_in,
    rvx_out_if.source     o_out
);

    localparam int LAST = STAGES - 1;

    t_res        w_res;
    t_ctl        w_ctl;
    t_div        w_div0;
    t_div        w_step [DIV_FIRST:LAST];

    logic        r_v   [0:LAST];
    t_res        r_res [0:LAST];
    t_ctl        r_ctl [0:LAST];
    t_div        r_div [0:LAST];

    logic [63:0] r_ma;
    logic [63:0] r_mb;
    logic [63:0] r_ll;
    logic [63:0] r_lh;
    logic [63:0] r_hl;
    logic [63:0] r_hh;
    logic [63:0] r_corr;
    logic [64:0] r_cross;
    logic [63:0] r_hhc;
    logic [63:0] r_ll2;
    logic [127:0] prod;
    logic [63:0] n_corr;
    t_res        n_res3;

    logic [63:0] fin_q;
    logic [63:0] fin_r;
    logic [63:0] fin_v;
    t_res        n_out;

    logic        adv;
    logic        push;
    logic        pop;
    logic        r_out_v;
    logic        r_skid_v;
    t_res        r_out;
    t_res        r_skid;

    rvx_exec u_exec (
        .i_insn           (i_in.insn),
        .i_pc             (i_in.pc),
        .i_insn_len       (i_in.insn_len),
        .i_rs1_value      (i_in.rs1_value),
        .i_rs2_value      (i_in.rs2_value),
        .i_rs2_fp_value   (i_in.rs2_fp_value),
        .i_privilege      (i_in.privilege),
        .i_fp_enabled     (i_in.fp_enabled),
        .i_counter_enable (i_in.counter_enable),
        .i_csr_data       (i_in.csr_data),
        .i_cycle_count    (i_in.cycle_count),
        .i_retired_count  (i_in.retired_count),
        .o_res            (w_res),
        .o_ctl            (w_ctl),
        .o_div            (w_div0)
    );

    for (genvar g = DIV_FIRST; g <= LAST; g++) begin : g_div
        rvx_div_step u_step (
            .i_st (r_div[g-1]),
            .o_st (w_step[g])
        );
    end

    assign adv        = !r_skid_v;
    assign i_in.ready = adv;
    assign push       = r_v[LAST] && adv;
    assign pop        = r_out_v && o_out.ready;

    // signed multiply-high corrections
    always_comb begin
        n_corr = '0;
        if (r_ctl[0].mulf == F3_MULH[1:0]) begin
            n_corr = (r_ma[63] ? r_mb : 64'd0) + (r_mb[63] ? r_ma : 64'd0);
        end else if (r_ctl[0].mulf == F3_MULHSU[1:0]) begin
            n_corr = r_ma[63] ? r_mb : 64'd0;
        end
    end

    assign prod = {r_hhc, r_ll2} + {31'd0, r_cross, 32'd0};

    always_comb begin
        n_res3 = r_res[2];
        if (r_ctl[2].unit == U_MUL) begin
            if (r_ctl[2].mulf == F3_MUL[1:0]) begin
                n_res3.result_value = r_ctl[2].word ? sx32(prod[63:0]) : prod[63:0];
            end else begin
                n_res3.result_value = prod[127:64];
            end
        end
    end

    assign fin_q = r_div[LAST].zero ? '1
                 : (r_div[LAST].neg_q ? (64'd0 - r_div[LAST].quo) : r_div[LAST].quo);
    assign fin_r = r_div[LAST].neg_r ? (64'd0 - r_div[LAST].rem) : r_div[LAST].rem;
    assign fin_v = r_div[LAST].is_rem ? fin_r : fin_q;

    always_comb begin
        n_out = r_res[LAST];
        if (r_ctl[LAST].unit == U_DIV) begin
            n_out.result_value = r_ctl[LAST].word ? sx32(fin_v) : fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= i_in.valid;
            for (int k = 1; k < STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res[0] <= w_res;
            r_ctl[0] <= w_ctl;
            r_div[0] <= w_div0;
            r_ma     <= i_in.rs1_value;
            r_mb     <= i_in.rs2_value;

            r_ll     <= r_ma[31:0]  * r_mb[31:0];
            r_lh     <= r_ma[31:0]  * r_mb[63:32];
            r_hl     <= r_ma[63:32] * r_mb[31:0];
            r_hh     <= r_ma[63:32] * r_mb[63:32];
            r_corr   <= n_corr;

            r_cross  <= {1'b0, r_lh} + {1'b0, r_hl};
            r_hhc    <= r_hh - r_corr;
            r_ll2    <= r_ll;

            for (int k = 1; k < DIV_FIRST; k++) begin
                r_ctl[k] <= r_ctl[k-1];
                r_div[k] <= r_div[k-1];
            end
            r_res[1] <= r_res[0];
            r_res[2] <= r_res[1];
            r_res[3] <= n_res3;

            for (int k = DIV_FIRST; k < STAGES; k++) begin
                r_res[k] <= r_res[k-1];
                r_ctl[k] <= r_ctl[k-1];
                r_div[k] <= w_step[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else if (push) begin
                r_out   <= n_out;
                r_out_v <= 1'b1;
            end else begin
                r_out_v <= 1'b0;
            end
        end else if (push) begin
            if (r_out_v) begin
                r_skid   <= n_out;
                r_skid_v <= 1'b1;
            end else begin
                r_out   <= n_out;
                r_out_v <= 1'b1;
            end
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.outcome       = r_out.outcome;
    assign o_out.trap_cause    = r_out.trap_cause;
    assign o_out.trap_value    = r_out.trap_value;
    assign o_out.result_value  = r_out.result_value;
    assign o_out.redirect      = r_out.redirect;
    assign o_out.target        = r_out.target;
    assign o_out.mem_addr      = r_out.mem_addr;
    assign o_out.mem_data      = r_out.mem_data;
    assign o_out.csr_write     = r_out.csr_write;
    assign o_out.csr_number    = r_out.csr_number;
    assign o_out.csr_new_value = r_out.csr_new_value;

    `RVX_ASSERT_IMPL(a_trap_clean, i_clk, i_rst_n, o_out.valid && o_out.outcome != OUT_EXEC, o_out.result_value == 64'd0 && !o_out.redirect && !o_out.csr_write && o_out.mem_addr == 64'd0)
    `RVX_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `RVX_ASSERT_NEXT(a_skid_hold, i_clk, i_rst_n, r_skid_v && !o_out.ready, r_skid_v && r_out_v)

endmodule

// ===== rtl/core/rvx_exec.sv =====
// Decode, legality, ALU, branch, memory address and CSR logic of the first stage.
module rvx_exec
    import rvx_pkg::*;
(
    input  logic [31:0] i_insn,
    input  logic [63:0] i_pc,
    input  logic [2:0]  i_insn_len,
    input  logic [63:0] i_rs1_value,
    input  logic [63:0] i_rs2_value,
    input  logic [63:0] i_rs2_fp_value,
    input  logic [1:0]  i_privilege,
    input  logic        i_fp_enabled,
    input  logic [2:0]  i_counter_enable,
    input  logic [63:0] i_csr_data,
    input  logic [63:0] i_cycle_count,
    input  logic [63:0] i_retired_count,
    output t_res        o_res,
    output t_ctl        o_ctl,
    output t_div        o_div
);

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rs1f;
    logic [4:0]  rs2f;
    logic [11:0] cnum;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] imm_i;
    logic [63:0] imm_s;
    logic [63:0] imm_b;
    logic [63:0] imm_j;
    logic [63:0] imm_u;
    logic [63:0] link;
    logic        word;
    logic        is_reg;
    logic [63:0] op2;
    logic [5:0]  sh;
    logic [63:0] sr_src;
    logic [63:0] sra_res;
    logic [63:0] srl_res;
    logic [63:0] sll_res;
    logic        sll_bad;
    logic        sr_bad;

    logic        d_uns;
    logic [63:0] da;
    logic [63:0] db;
    logic        na;
    logic        nb;

    logic [63:0] v;
    logic        ill;
    logic        csr_ok;
    logic [63:0] csr_old;
    logic [63:0] csr_src;

    assign op    = i_insn[6:0];
    assign f3    = i_insn[14:12];
    assign f7    = i_insn[31:25];
    assign rs1f  = i_insn[19:15];
    assign rs2f  = i_insn[24:20];
    assign cnum  = i_insn[31:20];
    assign a     = i_rs1_value;
    assign b     = i_rs2_value;
    assign imm_i = {{52{i_insn[31]}}, i_insn[31:20]};
    assign imm_s = {{52{i_insn[31]}}, i_insn[31:25], i_insn[11:7]};
    assign imm_b = {{51{i_insn[31]}}, i_insn[31], i_insn[7], i_insn[30:25],
                    i_insn[11:8], 1'b0};
    assign imm_j = {{43{i_insn[31]}}, i_insn[31], i_insn[19:12], i_insn[20],
                    i_insn[30:21], 1'b0};
    assign imm_u = {{32{i_insn[31]}}, i_insn[31:0] & UIMM_MASK};
    assign link  = i_pc + {61'd0, i_insn_len};

    assign word   = (op == OP_IMM_32) || (op == OP_REG_32);
    assign is_reg = (op == OP_REG) || (op == OP_REG_32);
    assign op2    = is_reg ? b : imm_i;
    assign sh     = is_reg ? (word ? {1'b0, b[4:0]} : b[5:0])
                           : (word ? {1'b0, i_insn[24:20]} : i_insn[25:20]);

    assign sr_src  = word ? (i_insn[30] ? sx32(a) : {32'd0, a[31:0]}) : a;
    assign sra_res = $signed(sr_src) >>> sh;
    assign srl_res = i_insn[30] ? sra_res : (sr_src >> sh);
    assign sll_res = a << sh;

    assign sll_bad = word ? (f7 != F7_BASE) : (i_insn[31:26] != F6_BASE);
    assign sr_bad  = word ? (f7 != F7_BASE && f7 != F7_ALT)
                          : (i_insn[31:26] != F6_BASE && i_insn[31:26] != F6_ALT);

    // divider operand preparation
    assign d_uns = f3[0];
    assign da    = word ? (d_uns ? {32'd0, a[31:0]} : sx32(a)) : a;
    assign db    = word ? (d_uns ? {32'd0, b[31:0]} : sx32(b)) : b;
    assign na    = !d_uns && da[63];
    assign nb    = !d_uns && db[63];

    assign o_div.rem    = '0;
    assign o_div.quo    = na ? (64'd0 - da) : da;
    assign o_div.dvs    = nb ? (64'd0 - db) : db;
    assign o_div.neg_q  = na ^ nb;
    assign o_div.neg_r  = na;
    assign o_div.is_rem = f3[1];
    assign o_div.zero   = (db == 64'd0);

    // CSR read and permission check
    always_comb begin
        csr_ok  = 1'b1;
        csr_old = '0;
        if (cnum[9:8] > i_privilege) begin
            csr_ok = 1'b0;
        end else if (cnum == CSR_FFLAGS || cnum == CSR_FRM || cnum == CSR_FCSR) begin
            csr_ok = i_fp_enabled;
            if (cnum == CSR_FFLAGS) begin
                csr_old = {59'd0, i_csr_data[4:0]};
            end else if (cnum == CSR_FRM) begin
                csr_old = {61'd0, i_csr_data[7:5]};
            end else begin
                csr_old = i_csr_data;
            end
        end else begin
            unique case (cnum)
                CSR_CYCLE, CSR_TIME, CSR_INSTRET: begin
                    csr_ok  = (i_privilege == PRIV_M) || i_counter_enable[cnum[1:0]];
                    csr_old = (cnum == CSR_INSTRET) ? i_retired_count : i_cycle_count;
                end
                CSR_MCYCLE:   csr_old = i_cycle_count;
                CSR_MINSTRET: csr_old = i_retired_count;
                CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID,
                CSR_MCONFIGPTR: csr_old = '0;
                CSR_MSTATUS, CSR_MISA, CSR_MIE, CSR_MTVEC, CSR_MCOUNTEREN,
                CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL,
                CSR_MIP: csr_old = i_csr_data;
                default: csr_ok = 1'b0;
            endcase
        end
    end

    assign csr_src = (f3 >= F3_CSRRWI) ? {59'd0, rs1f} : a;

    always_comb begin
        o_res     = '0;
        o_ctl     = '{unit: U_ALU, word: word, mulf: f3[1:0]};
        v         = '0;
        ill       = 1'b0;
        unique case (op)
            OP_LUI:   v = imm_u;
            OP_AUIPC: v = i_pc + imm_u;
            OP_JAL: begin
                o_res.redirect = 1'b1;
                o_res.target   = i_pc + imm_j;
                v              = link;
            end
            OP_JALR: begin
                ill            = (f3 != F3_ADD);
                o_res.redirect = 1'b1;
                o_res.target   = (a + imm_i) & ~64'd1;
                v              = link;
            end
            OP_BRANCH: begin
                unique case (f3)
                    F3_BEQ:  o_res.redirect = (a == b);
                    F3_BNE:  o_res.redirect = (a != b);
                    F3_BLT:  o_res.redirect = ($signed(a) < $signed(b));
                    F3_BGE:  o_res.redirect = !($signed(a) < $signed(b));
                    F3_BLTU: o_res.redirect = (a < b);
                    F3_BGEU: o_res.redirect = (a >= b);
                    default: ill = 1'b1;
                endcase
                o_res.target = o_res.redirect ? (i_pc + imm_b) : 64'd0;
            end
            OP_LOAD, OP_LOAD_FP, OP_STORE, OP_STORE_FP: begin
                if (op == OP_LOAD && f3 > F3_LDU_MAX) ill = 1'b1;
                if (op == OP_STORE && f3 > F3_SD) ill = 1'b1;
                if ((op == OP_LOAD_FP || op == OP_STORE_FP) &&
                    ((f3 != F3_FLW && f3 != F3_FLD) || !i_fp_enabled)) ill = 1'b1;
                if (op == OP_STORE || op == OP_STORE_FP) begin
                    o_res.mem_addr = a + imm_s;
                    o_res.mem_data = (op == OP_STORE_FP) ? i_rs2_fp_value : b;
                end else begin
                    o_res.mem_addr = a + imm_i;
                end
            end
            OP_AMO: begin
                if (f3 != F3_AMO_W && f3 != F3_AMO_D) ill = 1'b1;
                if (i_insn[31:27] == AMO_LR && rs2f != 5'd0) ill = 1'b1;
                o_res.mem_addr = a;
                o_res.mem_data = b;
            end
            OP_IMM, OP_IMM_32, OP_REG, OP_REG_32: begin
                if (is_reg && f7 == F7_MULDIV) begin
                    if (word && f3 != F3_MUL && f3 < F3_DIV) ill = 1'b1;
                    o_ctl.unit = (f3 >= F3_DIV) ? U_DIV : U_MUL;
                end else begin
                    if (is_reg && f7 != F7_BASE &&
                        !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) ill = 1'b1;
                    if (word && f3 != F3_ADD && f3 != F3_SLL && f3 != F3_SR) ill = 1'b1;
                    unique case (f3)
                        F3_ADD:  v = (is_reg && f7 == F7_ALT) ? (a - b) : (a + op2);
                        F3_SLT:  v = {63'd0, $signed(a) < $signed(op2)};
                        F3_SLTU: v = {63'd0, a < op2};
                        F3_XOR:  v = a ^ op2;
                        F3_OR:   v = a | op2;
                        F3_AND:  v = a & op2;
                        F3_SLL: begin
                            if (!is_reg && sll_bad) ill = 1'b1;
                            v = sll_res;
                        end
                        default: begin
                            if (!is_reg && sr_bad) ill = 1'b1;
                            v = srl_res;
                        end
                    endcase
                end
            end
            OP_MISC_MEM: begin
                if (f3 != F3_FENCE && f3 != F3_FENCEI) ill = 1'b1;
                if (f3 == F3_FENCEI) begin
                    o_res.redirect = 1'b1;
                    o_res.target   = link;
                end
            end
            OP_SYSTEM: begin
                if (f3 == F3_PRIV) begin
                    if (i_insn == INSN_ECALL) begin
                        o_res.outcome    = OUT_TRAP;
                        o_res.trap_cause = CAUSE_ECALL_BASE + {2'd0, i_privilege};
                    end else if (i_insn == INSN_EBREAK) begin
                        o_res.outcome    = OUT_TRAP;
                        o_res.trap_cause = CAUSE_BREAKPOINT;
                        o_res.trap_value = i_pc;
                    end else if (i_insn == INSN_MRET && i_privilege == PRIV_M) begin
                        o_res.redirect = 1'b1;
                        o_res.target   = i_csr_data;
                    end else if (!(i_insn == INSN_WFI && i_privilege == PRIV_M)) begin
                        ill = 1'b1;
                    end
                end else if (f3 == F3_CSR_RSV) begin
                    ill = 1'b1;
                end else begin
                    o_res.csr_number = cnum;
                    o_res.csr_write  = (f3[1:0] == CSR_OP_WRITE) || (rs1f != 5'd0);
                    if (!csr_ok) ill = 1'b1;
                    if (o_res.csr_write && cnum[11:10] == CSR_RO_TOP) ill = 1'b1;
                    if (f3[1:0] == CSR_OP_WRITE) begin
                        o_res.csr_new_value = csr_src;
                    end else if (f3[1:0] == CSR_OP_SET) begin
                        o_res.csr_new_value = csr_old | csr_src;
                    end else begin
                        o_res.csr_new_value = csr_old & ~csr_src;
                    end
                    v = csr_old;
                end
            end
            OP_MADD, OP_MSUB, OP_NMSUB, OP_NMADD, OP_FP: begin
                if (!i_fp_enabled) ill = 1'b1;
                o_res.outcome = OUT_FPU;
            end
            default: ill = 1'b1;
        endcase

        if (ill) begin
            o_res.outcome    = OUT_TRAP;
            o_res.trap_cause = CAUSE_ILLEGAL;
            o_res.trap_value = {32'd0, i_insn};
        end
        if (o_res.outcome != OUT_EXEC) begin
            v                   = '0;
            o_res.redirect      = 1'b0;
            o_res.target        = '0;
            o_res.mem_addr      = '0;
            o_res.mem_data      = '0;
            o_res.csr_write     = 1'b0;
            o_res.csr_number    = '0;
            o_res.csr_new_value = '0;
            o_ctl.unit          = U_ALU;
        end
        if (o_ctl.unit == U_ALU && word) begin
            v = sx32(v);
        end
        o_res.result_value = v;
    end

endmodule

// ===== rtl/core/rvx_div_step.sv =====
// One restoring division step: shift in a dividend bit, trial subtract.
module rvx_div_step
    import rvx_pkg::*;
(
    input  t_div i_st,
    output t_div o_st
);

    logic [64:0] trial;
    logic [65:0] diff;
    logic        ge;

    assign trial = {i_st.rem, i_st.quo[63]};
    assign diff  = {1'b0, trial} - {2'b00, i_st.dvs};
    assign ge    = !diff[65];

    always_comb begin
        o_st     = i_st;
        o_st.rem = ge ? diff[63:0] : trial[63:0];
        o_st.quo = {i_st.quo[62:0], ge};
    end

endmodule
